### hw/rtl/mbr_pkg.sv
// mbr partition table parser package: types and constants
`timescale 1ns / 1ps
package mbr_pkg;
    localparam int MAX_PARTITIONS   = 64;
    localparam int MAX_SECTOR_BYTES = 4096;
    localparam int CNT_W            = 7;
    localparam int POS_W            = 13;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;

    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_REQ    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [POS_W-1:0] TABLE_AT = 13'h1BE;
    localparam logic [POS_W-1:0] SIG_AT   = 13'h1B8;
    localparam logic [POS_W-1:0] MAGIC_AT = 13'h1FE;

    localparam logic [2:0] REG_SECTOR_SIZE = 3'h0;
    localparam logic [2:0] REG_ONLY_REC    = 3'h4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_MUL_START,
        ST_MUL_LEN,
        ST_EMIT,
        ST_TAIL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [43:0] start_offset;
        logic [43:0] length_bytes;
        logic [31:0] hidden_sectors;
        logic [7:0]  part_type;
        logic        boot;
        logic        recognized;
        logic [6:0]  part_number;
        logic [31:0] next_lba;
        logic [31:0] disk_signature;
        logic        status;
    } result_t;

    function automatic logic is_known_fs(input logic [7:0] t);
        logic [7:0] b;
        b = t[7] ? {2'b00, t[5:0]} : t;
        return (b == 8'h01) || (b == 8'h04) || (b == 8'h06) || (b == 8'h07) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0E);
    endfunction

    function automatic logic is_ext(input logic [7:0] t);
        return (t == 8'h05) || (t == 8'h0F);
    endfunction
endpackage

### hw/rtl/mbr_partition_table_parser.sv
// mbr partition table parser top level
//
// channel  direction  handshake         payload
// s_       in         tvalid/tready     tdata op, data_byte
// m_       out        tvalid/tready     tdata result fields, tuser kind, tlast last
// apb      in         psel/penable      sector_size, only_recognized
//
// data bytes are taken only while idle; the last byte of a sector with a good magic
// starts the entry walk: per entry two entry-store reads, two passes through the one
// 32x13 multiplier, an entry transfer unless the entry is skipped and one step to the
// next entry, then the request or finish transfer; the block is not ready meanwhile.
// aresetn is synchronous; the entry store has no reset.
// a stalled m_ side holds the walk at the output register.
`timescale 1ns / 1ps
module mbr_partition_table_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // op[1:0], data_byte[9:2], zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    // start_offset, length_bytes, hidden_sectors, part_type, boot, recognized,
    // part_number, next_lba, disk_signature, status, zero fill
    output logic [207:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,   // last
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mbr_pkg::*;

    state_t state_reg, state_next;
    logic [12:0] sector_size_reg;
    logic        only_rec_reg;
    logic [POS_W-1:0] pos_reg;
    logic [15:0] magic_reg;
    logic [31:0] sig_reg, base_reg, ext_org_reg, link_reg;
    logic        first_reg, active_reg, saw_reg;
    logic [CNT_W-1:0] ent_cnt_reg, rec_cnt_reg, pass_reg;
    logic [1:0]  idx_reg;
    logic [7:0]  type_reg;
    logic        boot_reg;
    logic [31:0] rel_reg, len_reg, abs_reg;
    logic [43:0] start_off_reg;
    result_t     res_reg;
    logic        m_valid_reg;
    logic        after_entry_reg;

    logic [31:0] mem [16];
    logic [31:0] rd_reg;
    logic [7:0]  hdr_reg;
    logic [1:0]  rd_word, hdr_word;

    logic [1:0]  op;
    logic [7:0]  db;
    logic        s_fire, m_fire, wr;
    logic [12:0] eff;
    logic [31:0] mul_a;
    logic [43:0] mul_full;

    assign op = s_tdata[1:0];
    assign db = s_tdata[9:2];
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_valid_reg && m_tready;
    assign eff = (sector_size_reg < 13'd512) ? 13'd512 :
                 (sector_size_reg > 13'(MAX_SECTOR_BYTES)) ? 13'(MAX_SECTOR_BYTES) :
                 sector_size_reg;

    always_comb begin
        prdata = 32'd0;
        unique case (paddr)
            REG_SECTOR_SIZE: prdata = {19'd0, sector_size_reg};
            REG_ONLY_REC:    prdata = {31'd0, only_rec_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // the one shared multiplier
    assign mul_a = (state_reg == ST_MUL_START) ? abs_reg : len_reg;
    assign mul_full = 44'(mul_a) * 44'(eff);

    // entry store, one 32-bit word per four entry bytes, written by byte lane
    logic [5:0] tbl_off;
    assign tbl_off = 6'(pos_reg - TABLE_AT);
    always_ff @(posedge aclk) begin
        if (s_fire && op == OP_BYTE && active_reg &&
            pos_reg >= TABLE_AT && pos_reg < TABLE_AT + 13'd64)
            mem[tbl_off[5:2]][8*tbl_off[1:0] +: 8] <= db;
    end
    always_comb begin
        rd_word  = 2'd2;
        hdr_word = 2'd1;
        if (state_reg == ST_RD1) begin
            rd_word  = 2'd3;
            hdr_word = 2'd0;
        end
    end
    always_ff @(posedge aclk) begin
        rd_reg  <= mem[{idx_reg, rd_word}];
        hdr_reg <= mem[{idx_reg, hdr_word}][7:0];
    end

    logic last_byte;
    assign last_byte = (32'(pos_reg) + 32'd1 >= 32'(eff));

    // entry decisions
    logic cur_ext, cur_skip, cur_rec;
    assign cur_ext  = is_ext(type_reg);
    assign cur_skip = only_rec_reg && (cur_ext || type_reg == 8'd0 || len_reg == 32'd0);
    assign cur_rec  = is_known_fs(type_reg);

    logic tail_end;
    assign tail_end = !saw_reg || link_reg == base_reg ||
                      ent_cnt_reg >= CNT_W'(MAX_PARTITIONS) ||
                      pass_reg >= CNT_W'(MAX_PARTITIONS);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && active_reg && op == OP_BYTE && last_byte) begin
                    if (magic_reg != 16'hAA55 &&
                        !(pos_reg == MAGIC_AT + 13'd1 && {db, magic_reg[7:0]} == 16'hAA55)
                        && !(pos_reg == MAGIC_AT && {magic_reg[15:8], db} == 16'hAA55))
                        state_next = ST_OUT;
                    else if (ent_cnt_reg >= CNT_W'(MAX_PARTITIONS))
                        state_next = ST_TAIL;
                    else
                        state_next = ST_RD0;
                end else if (s_fire && active_reg && op == OP_FAIL)
                    state_next = ST_OUT;
            end
            ST_RD0:       state_next = ST_RD1;
            ST_RD1:       state_next = ST_MUL_START;
            ST_MUL_START: state_next = ST_MUL_LEN;
            ST_MUL_LEN:   state_next = cur_skip ? ST_EMIT : ST_OUT;
            ST_EMIT: begin
                if (idx_reg == 2'd3 || ent_cnt_reg >= CNT_W'(MAX_PARTITIONS))
                    state_next = ST_TAIL;
                else
                    state_next = ST_RD0;
            end
            ST_TAIL: state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) begin
                    if (after_entry_reg) state_next = ST_EMIT;
                    else state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sector_size_reg <= 13'd512;
            only_rec_reg <= 1'b0;
            pos_reg <= '0;
            magic_reg <= '0;
            sig_reg <= '0;
            base_reg <= '0;
            ext_org_reg <= '0;
            link_reg <= '0;
            first_reg <= 1'b1;
            active_reg <= 1'b0;
            saw_reg <= 1'b0;
            ent_cnt_reg <= '0;
            rec_cnt_reg <= '0;
            pass_reg <= '0;
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
            after_entry_reg <= 1'b0;
        end else begin
            result_t rs;
            rs = '0;
            state_reg <= state_next;
            if (wr) begin
                if (paddr == REG_SECTOR_SIZE) sector_size_reg <= pwdata[12:0];
                else if (paddr == REG_ONLY_REC) only_rec_reg <= pwdata[0];
            end
            if (m_fire) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && op == OP_START) begin
                        pos_reg <= '0; magic_reg <= '0; sig_reg <= '0;
                        base_reg <= '0; ext_org_reg <= '0; link_reg <= '0;
                        first_reg <= 1'b1; ent_cnt_reg <= '0; rec_cnt_reg <= '0;
                        pass_reg <= '0; active_reg <= 1'b1;
                    end else if (s_fire && active_reg && op == OP_FAIL) begin
                        rs.kind = KIND_FINISH;
                        rs.last = 1'b1;
                        rs.part_number = first_reg ? '0 : ent_cnt_reg;
                        rs.disk_signature = first_reg ? 32'd0 : sig_reg;
                        rs.status = first_reg;
                        res_reg <= rs;
                        m_valid_reg <= 1'b1;
                        after_entry_reg <= 1'b0;
                        active_reg <= 1'b0;
                        pos_reg <= '0;
                    end else if (s_fire && active_reg && op == OP_BYTE) begin
                        logic [15:0] mg;
                        logic [31:0] sg;
                        logic        bad_end;
                        mg = magic_reg;
                        sg = sig_reg;
                        if (first_reg && pos_reg >= SIG_AT && pos_reg < SIG_AT + 13'd4)
                            sg[8*(pos_reg[1:0]) +: 8] = db;
                        if (pos_reg == MAGIC_AT) mg[7:0] = db;
                        else if (pos_reg == MAGIC_AT + 13'd1) mg[15:8] = db;
                        bad_end = last_byte && mg != 16'hAA55;
                        magic_reg <= mg;
                        sig_reg <= (bad_end && first_reg) ? 32'd0 : sg;
                        pos_reg <= bad_end ? '0 : pos_reg + 13'd1;
                        idx_reg <= '0;
                        saw_reg <= 1'b0;
                        if (bad_end) begin
                            rs.kind = KIND_FINISH;
                            rs.last = 1'b1;
                            rs.part_number = ent_cnt_reg;
                            rs.disk_signature = first_reg ? 32'd0 : sg;
                            res_reg <= rs;
                            m_valid_reg <= 1'b1;
                            after_entry_reg <= 1'b0;
                            active_reg <= 1'b0;
                        end
                    end
                end
                ST_RD0: begin
                end
                ST_RD1: begin
                    type_reg <= hdr_reg;
                    rel_reg <= rd_reg;
                    if (is_ext(hdr_reg)) begin
                        saw_reg <= 1'b1;
                        if (first_reg) begin
                            ext_org_reg <= rd_reg;
                            abs_reg <= base_reg + rd_reg;
                            link_reg <= base_reg + rd_reg;
                        end else begin
                            abs_reg <= ext_org_reg + rd_reg;
                            link_reg <= ext_org_reg + rd_reg;
                        end
                    end else
                        abs_reg <= base_reg + rd_reg;
                end
                ST_MUL_START: begin
                    len_reg <= rd_reg;
                    boot_reg <= hdr_reg[7];
                    start_off_reg <= mul_full;
                end
                ST_MUL_LEN: begin
                    if (!cur_skip) begin
                        rs.kind = KIND_ENTRY;
                        rs.start_offset = start_off_reg;
                        rs.length_bytes = mul_full;
                        rs.hidden_sectors = rel_reg;
                        rs.part_type = type_reg;
                        rs.boot = boot_reg;
                        rs.recognized = cur_rec;
                        rs.part_number = cur_rec ? rec_cnt_reg + 7'd1 : '0;
                        res_reg <= rs;
                        if (cur_rec) rec_cnt_reg <= rec_cnt_reg + 7'd1;
                        ent_cnt_reg <= ent_cnt_reg + 7'd1;
                        m_valid_reg <= 1'b1;
                        after_entry_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    idx_reg <= idx_reg + 2'd1;
                end
                ST_TAIL: begin
                    first_reg <= 1'b0;
                    rs.last = 1'b1;
                    after_entry_reg <= 1'b0;
                    m_valid_reg <= 1'b1;
                    pos_reg <= '0;
                    if (tail_end) begin
                        rs.kind = KIND_FINISH;
                        rs.part_number = ent_cnt_reg;
                        rs.disk_signature = sig_reg;
                        active_reg <= 1'b0;
                    end else begin
                        rs.kind = KIND_REQ;
                        rs.next_lba = link_reg;
                        pass_reg <= pass_reg + 7'd1;
                        base_reg <= link_reg;
                    end
                    res_reg <= rs;
                end
                ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.disk_signature, res_reg.next_lba,
                       res_reg.part_number, res_reg.recognized, res_reg.boot,
                       res_reg.part_type, res_reg.hidden_sectors,
                       res_reg.length_bytes, res_reg.start_offset};
endmodule

### sim/mbr_parser_checker.sv
// mbr partition table parser checker: predicts results from observed transfers and compares
`timescale 1ns / 1ps
module mbr_parser_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [207:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);
    import mbr_pkg::*;

    result_t     result_q[$];

    logic [12:0] cfg_sector_size;
    logic        cfg_only_rec;

    logic [12:0] byte_pos;
    logic [7:0]  table_bytes[64];
    logic [15:0] magic;
    logic [31:0] sig_latch;
    logic [31:0] base_lba;
    logic [31:0] ext_origin;
    logic [31:0] link_lba;
    logic        on_first;
    int          entries_seen;
    int          known_seen;
    int          links_taken;
    logic        walking;

    function automatic logic [12:0] sector_bytes(input logic [12:0] sz);
        if (sz < 13'd512)
            return 13'd512;
        if (sz > 13'(MAX_SECTOR_BYTES))
            return 13'(MAX_SECTOR_BYTES);
        return sz;
    endfunction

    function automatic logic fs_known(input logic [7:0] t);
        logic [7:0] masked;
        masked = t[7] ? (t & 8'h3F) : t;
        case (masked)
            8'h01, 8'h04, 8'h06, 8'h07, 8'h0B, 8'h0C, 8'h0E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] word_at(input int idx);
        return {table_bytes[idx+3], table_bytes[idx+2], table_bytes[idx+1], table_bytes[idx]};
    endfunction

    task automatic new_walk();
        byte_pos = '0;
        magic = '0;
        sig_latch = '0;
        base_lba = '0;
        ext_origin = '0;
        link_lba = '0;
        on_first = 1'b1;
        entries_seen = 0;
        known_seen = 0;
        links_taken = 0;
    endtask

    task automatic push_finish(input logic st);
        result_t r;
        r = '0;
        r.kind = KIND_FINISH;
        r.last = 1'b1;
        r.part_number = 7'(entries_seen);
        r.disk_signature = sig_latch;
        r.status = st;
        result_q.push_back(r);
        walking = 1'b0;
        byte_pos = '0;
    endtask

    task automatic decode_table();
        logic [31:0] tbl_base;
        logic [12:0] sz;
        logic        has_ext;
        logic [7:0]  ptype;
        logic [31:0] rel;
        logic [31:0] len;
        logic [31:0] abs_lba;
        logic [63:0] prod;
        result_t     r;
        tbl_base = base_lba;
        sz = sector_bytes(cfg_sector_size);
        has_ext = 1'b0;
        if (magic != 16'hAA55) begin
            if (on_first)
                sig_latch = '0;
            push_finish(1'b0);
            return;
        end
        for (int i = 0; i < 4 && entries_seen < MAX_PARTITIONS; i++) begin
            ptype = table_bytes[i*16+4];
            rel = word_at(i*16+8);
            len = word_at(i*16+12);
            abs_lba = tbl_base + rel;
            if (ptype == 8'h05 || ptype == 8'h0F) begin
                if (on_first)
                    ext_origin = rel;
                else
                    abs_lba = ext_origin + rel;
                link_lba = abs_lba;
                has_ext = 1'b1;
                if (cfg_only_rec)
                    continue;
            end else if (ptype == 8'h00 || len == 32'd0) begin
                if (cfg_only_rec)
                    continue;
            end
            r = '0;
            r.kind = KIND_ENTRY;
            prod = 64'(abs_lba) * 64'(sz);
            r.start_offset = prod[43:0];
            prod = 64'(len) * 64'(sz);
            r.length_bytes = prod[43:0];
            r.hidden_sectors = rel;
            r.part_type = ptype;
            r.boot = table_bytes[i*16][7];
            r.recognized = fs_known(ptype);
            if (r.recognized) begin
                known_seen++;
                r.part_number = 7'(known_seen);
            end
            entries_seen++;
            result_q.push_back(r);
        end
        on_first = 1'b0;
        if (!has_ext || link_lba == tbl_base || entries_seen >= MAX_PARTITIONS ||
            links_taken >= MAX_PARTITIONS) begin
            push_finish(1'b0);
            return;
        end
        links_taken++;
        r = '0;
        r.kind = KIND_REQ;
        r.last = 1'b1;
        r.next_lba = link_lba;
        result_q.push_back(r);
        base_lba = link_lba;
        byte_pos = '0;
    endtask

    task automatic take_item(input logic [1:0] op, input logic [7:0] b);
        int p;
        if (op == OP_START) begin
            new_walk();
            walking = 1'b1;
            return;
        end
        if (!walking)
            return;
        if (op == OP_FAIL) begin
            if (on_first) begin
                sig_latch = '0;
                entries_seen = 0;
                push_finish(1'b1);
            end else begin
                push_finish(1'b0);
            end
            return;
        end
        if (op != OP_BYTE)
            return;
        p = byte_pos;
        if (on_first && p >= SIG_AT && p < SIG_AT + 4)
            sig_latch[(p-SIG_AT)*8 +: 8] = b;
        if (p >= TABLE_AT && p < TABLE_AT + 64)
            table_bytes[p-TABLE_AT] = b;
        else if (p == MAGIC_AT)
            magic[7:0] = b;
        else if (p == MAGIC_AT + 1)
            magic[15:8] = b;
        if (p + 1 >= sector_bytes(cfg_sector_size))
            decode_table();
        else
            byte_pos = 13'(p + 1);
    endtask

    task automatic compare_result();
        result_t got;
        result_t want;
        got.kind = m_tuser;
        got.last = m_tlast;
        got.start_offset = m_tdata[43:0];
        got.length_bytes = m_tdata[87:44];
        got.hidden_sectors = m_tdata[119:88];
        got.part_type = m_tdata[127:120];
        got.boot = m_tdata[128];
        got.recognized = m_tdata[129];
        got.part_number = m_tdata[136:130];
        got.next_lba = m_tdata[168:137];
        got.disk_signature = m_tdata[200:169];
        got.status = m_tdata[201];
        if (result_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result transfer: kind %0d tdata %h", m_tuser, m_tdata);
            return;
        end
        want = result_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) begin
                $display("result mismatch at %0t", $realtime);
                $display("  expected kind %0d last %0d start %h len %h hid %h type %h boot %0d",
                         want.kind, want.last, want.start_offset, want.length_bytes,
                         want.hidden_sectors, want.part_type, want.boot);
                $display("           rec %0d num %0d next %h sig %h status %0d",
                         want.recognized, want.part_number, want.next_lba,
                         want.disk_signature, want.status);
                $display("  actual   kind %0d last %0d start %h len %h hid %h type %h boot %0d",
                         got.kind, got.last, got.start_offset, got.length_bytes,
                         got.hidden_sectors, got.part_type, got.boot);
                $display("           rec %0d num %0d next %h sig %h status %0d",
                         got.recognized, got.part_number, got.next_lba,
                         got.disk_signature, got.status);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors = 0;
            cfg_sector_size = 13'd512;
            cfg_only_rec = 1'b0;
            new_walk();
            walking = 1'b0;
            result_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                compare_result();
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_SECTOR_SIZE)
                    cfg_sector_size = pwdata[12:0];
                else if (paddr == REG_ONLY_REC)
                    cfg_only_rec = pwdata[0];
            end
            if (s_tvalid && s_tready)
                take_item(s_tdata[1:0], s_tdata[9:2]);
        end
        pending = result_q.size();
    end
endmodule

### sim/tb_mbr_partition_table_parser.sv
// mbr partition table parser testbench top: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module tb_mbr_partition_table_parser;
    import mbr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;   // op[1:0], data_byte[9:2], zero fill
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;   // start_offset .. status, zero fill
    logic [1:0]   m_tuser;   // kind
    logic         m_tlast;   // last
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int           errors;
    int           pending;
    int           cycles;
    int           done_count;
    logic [1:0]   done_kind;
    logic         gaps_on;
    int           stall_left;
    logic [12:0]  cur_size;
    logic [7:0]   sector[4096];

    mbr_partition_table_parser dut (.*);

    mbr_parser_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tlast) begin
            done_kind <= m_tuser;
            done_count <= done_count + 1;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(15) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (gaps_on && $urandom_range(7) == 0)
                stall_left <= gap_len();
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] b);
        int g;
        g = (gaps_on && $urandom_range(5) == 0) ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, b, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [12:0] sz, input logic only);
        go_quiet();
        reg_write(REG_SECTOR_SIZE, {19'd0, sz});
        reg_write(REG_ONLY_REC, {31'd0, only});
        if (sz < 13'd512)
            cur_size = 13'd512;
        else if (sz > 13'(MAX_SECTOR_BYTES))
            cur_size = 13'(MAX_SECTOR_BYTES);
        else
            cur_size = sz;
    endtask

    function automatic logic [7:0] pick_type(input logic plain);
        logic [7:0] t;
        case ($urandom_range(6))
            0, 1, 2: begin
                case ($urandom_range(6))
                    0: t = 8'h01;
                    1: t = 8'h04;
                    2: t = 8'h06;
                    3: t = 8'h07;
                    4: t = 8'h0B;
                    5: t = 8'h0C;
                    default: t = 8'h0E;
                endcase
                if ($urandom_range(3) == 0)
                    t = t | 8'h80 | ($urandom_range(1) ? 8'h40 : 8'h00);
            end
            3: t = 8'h00;
            default: t = 8'($urandom);
        endcase
        if (plain && (t == 8'h05 || t == 8'h0F))
            t = 8'h83;
        return t;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(5000);
            default: return $urandom;
        endcase
    endfunction

    // ext_slot < 0 builds a table with no link
    task automatic build_sector(input int ext_slot, input logic [31:0] ext_rel,
                                input logic empty_rest, input logic good_magic);
        logic [7:0]  t;
        logic [31:0] rel;
        logic [31:0] len;
        for (int i = 0; i < cur_size; i++)
            sector[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) begin
            if (i == ext_slot) begin
                t = $urandom_range(1) ? 8'h05 : 8'h0F;
                rel = ext_rel;
            end else begin
                t = empty_rest ? 8'h00 : pick_type(1'b1);
                rel = pick_word();
            end
            len = pick_word();
            sector[TABLE_AT + i*16 + 4] = t;
            for (int k = 0; k < 4; k++) begin
                sector[TABLE_AT + i*16 + 8 + k] = rel[k*8 +: 8];
                sector[TABLE_AT + i*16 + 12 + k] = len[k*8 +: 8];
            end
        end
        sector[MAGIC_AT] = good_magic ? 8'h55 : 8'($urandom_range(255));
        sector[MAGIC_AT + 1] = good_magic ? 8'hAA : 8'h00;
    endtask

    // returns 1 when the table asked for another link
    task automatic send_sector(output logic linked);
        int prior_done;
        prior_done = done_count;
        for (int i = 0; i < cur_size; i++)
            send(OP_BYTE, sector[i]);
        s_tvalid <= 1'b0;
        wait (done_count != prior_done);
        @(posedge aclk);
        linked = (done_kind == KIND_REQ);
    endtask

    task automatic run_walk(input int tables, input logic empty_rest);
        logic        linked;
        logic [31:0] prev_rel;
        logic [31:0] rel;
        int          ending;
        gaps_on = ($urandom_range(3) != 0);
        send(OP_START, 8'($urandom));
        prev_rel = 32'd0;
        for (int n = 0; n < tables; n++) begin
            rel = 32'(n + 1 + $urandom_range(3) * 100);
            if (n == tables - 1) begin
                ending = $urandom_range(9);
                if (ending == 0) begin
                    send(OP_FAIL, 8'($urandom));
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                    @(posedge aclk);
                    return;
                end
                if (ending == 1)
                    build_sector($urandom_range(3), rel, empty_rest, 1'b0);
                else if (ending == 2)
                    build_sector($urandom_range(3), prev_rel, empty_rest, 1'b1);
                else
                    build_sector(-1, 32'd0, empty_rest, 1'b1);
            end else begin
                build_sector($urandom_range(3), rel, empty_rest, 1'b1);
            end
            send_sector(linked);
            if (!linked)
                return;
            prev_rel = rel;
        end
    endtask

    task automatic idle_noise();
        repeat ($urandom_range(3)) begin
            case ($urandom_range(2))
                0: send(OP_BYTE, 8'($urandom));
                1: send(OP_FAIL, 8'($urandom));
                default: send(OP_FAIL | OP_BYTE, 8'($urandom));
            endcase
        end
    endtask

    initial begin
        logic linked;
        gaps_on = 1'b0;
        cur_size = 13'd512;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ignored while idle
        send(OP_BYTE, 8'hFF);
        send(OP_FAIL, 8'h00);
        send(OP_FAIL | OP_BYTE, 8'hA5);
        // read failure on the first table
        send(OP_START, 8'h00);
        send(OP_FAIL, 8'h00);
        go_quiet();
        // restart in the middle of a sector, then bad magic on the first table
        send(OP_START, 8'h00);
        for (int i = 0; i < 100; i++)
            send(OP_BYTE, 8'($urandom));
        send(OP_START, 8'h00);
        build_sector(0, 32'd0, 1'b0, 1'b0);
        send_sector(linked);
        // first table linking to itself
        send(OP_START, 8'h00);
        build_sector(1, 32'd0, 1'b0, 1'b1);
        send_sector(linked);
        // read failure on a later table
        run_walk(1, 1'b0);
        send(OP_START, 8'h00);
        build_sector(3, 32'd7, 1'b0, 1'b1);
        send_sector(linked);
        if (linked)
            send(OP_FAIL, 8'h00);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(13'd512, 1'b0);
                1: set_config(13'd512, 1'b1);
                2: set_config(13'd4096, 1'b0);
                3: set_config(13'd100, 1'b1);
                4: set_config(13'h1FFF, 1'b0);
                5: set_config(13'd1000, 1'b1);
                6: set_config(13'd4095, 1'b1);
                default: set_config(13'd512, 1'b0);
            endcase
            if (cur_size > 13'd1000) begin
                run_walk(2, 1'b0);
            end else begin
                repeat (6) begin
                    idle_noise();
                    run_walk($urandom_range(5, 1), 1'b0);
                end
            end
        end
        // entry limit, then link limit with nothing but a link and empty entries in each table
        set_config(13'd512, 1'b0);
        run_walk(30, 1'b0);
        set_config(13'd512, 1'b1);
        run_walk(70, 1'b1);

        go_quiet();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
hw/rtl/mbr_pkg.sv
hw/rtl/mbr_partition_table_parser.sv
sim/mbr_parser_checker.sv
sim/tb_mbr_partition_table_parser.sv
